// ===== rtl/sci_pkg.sv =====
// ----------------------------------------------------------------------------
// sci_pkg
// Shared constants and transaction types for the segment/circle intersect.
// ----------------------------------------------------------------------------
package sci_pkg;

	localparam int COORD_BITS = 16;
	localparam int PIPE_DEPTH = 6;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] start_x;
		logic signed [COORD_BITS-1:0] start_y;
		logic signed [COORD_BITS-1:0] end_x;
		logic signed [COORD_BITS-1:0] end_y;
		logic signed [COORD_BITS-1:0] center_x;
		logic signed [COORD_BITS-1:0] center_y;
		logic [COORD_BITS-2:0]        radius;
	} in_t;

	typedef struct packed {
		logic hit;
		logic degenerate;
	} out_t;

	// decision flags carried down the pipe
	typedef struct packed {
		logic deg;
		logic decided;
		logic early_hit;
		logic geo_ok;
	} flag_t;

endpackage

// ===== rtl/segment_circle_intersect.sv =====
// ----------------------------------------------------------------------------
// segment_circle_intersect
// Exact segment versus circle boundary test, six-stage pipeline.
//
// in_valid/in_ready/in_data take one transaction: a segment (start, end) and
// a circle (center, radius), coordinates signed Q12.4 and radius unsigned
// Q11.4. out_valid/out_ready/out_data return one transaction per input, in
// order: hit, and degenerate for a zero-length segment (hit is then 0).
// One transaction is taken per cycle while out_ready is high; every stage
// has its own valid bit and loads when it is empty or the stage after it
// moves, so bubbles close up under a stall.
// When the receiver holds out_ready low the pipe fills and in_ready drops once
// all six stages hold data. The widest step is the squaring of the cross
// product and of r*d, split into half-width partial products one stage ahead
// of their assembly.
// arst_n clears all valid bits; nothing is in flight after reset.
// ----------------------------------------------------------------------------
module segment_circle_intersect (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  sci_pkg::in_t   in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output sci_pkg::out_t  out_data
);

	localparam int W   = sci_pkg::COORD_BITS;
	localparam int DW  = W + 1;
	localparam int RW  = W - 1;
	localparam int RRW = 2 * RW;
	localparam int PW  = 2 * DW;
	localparam int SW  = PW + 2;
	localparam int MW  = RW + DW;
	localparam int K   = PW / 2;
	localparam int K2  = 2 * K;
	localparam int K4  = 4 * K;
	localparam int QW  = K4 + 1;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;

	assign en6      = !v_s6 || out_ready;
	assign en5      = !v_s5 || en6;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	// stage 1: differences
	logic signed [DW-1:0] sx, sy, ex, ey, cx, cy;
	logic signed [DW-1:0] dx_s1, dy_s1, fx_s1, fy_s1, gx_s1, gy_s1;
	logic [RW-1:0]        r_s1;
	logic                 deg_s1;

	assign sx = {in_data.start_x[W-1], in_data.start_x};
	assign sy = {in_data.start_y[W-1], in_data.start_y};
	assign ex = {in_data.end_x[W-1], in_data.end_x};
	assign ey = {in_data.end_y[W-1], in_data.end_y};
	assign cx = {in_data.center_x[W-1], in_data.center_x};
	assign cy = {in_data.center_y[W-1], in_data.center_y};

	always_ff @(posedge clk) begin
		if (en1) begin
			dx_s1  <= ex - sx;
			dy_s1  <= ey - sy;
			fx_s1  <= sx - cx;
			fy_s1  <= sy - cy;
			gx_s1  <= ex - cx;
			gy_s1  <= ey - cy;
			r_s1   <= in_data.radius;
			deg_s1 <= (in_data.start_x == in_data.end_x) && (in_data.start_y == in_data.end_y);
		end
	end

	// stage 2: products
	logic [DW-1:0]        adx, ady;
	logic signed [PW-1:0] fx2_s2, fy2_s2, gx2_s2, gy2_s2, dx2_s2, dy2_s2;
	logic signed [PW-1:0] fxdx_s2, fydy_s2, dxfy_s2, dyfx_s2;
	logic [RRW-1:0]       rr_s2;
	logic [MW-1:0]        mx_s2, my_s2;
	logic                 deg_s2;

	assign adx = dx_s1[DW-1] ? DW'(-dx_s1) : DW'(dx_s1);
	assign ady = dy_s1[DW-1] ? DW'(-dy_s1) : DW'(dy_s1);

	always_ff @(posedge clk) begin
		if (en2) begin
			fx2_s2  <= PW'(fx_s1) * PW'(fx_s1);
			fy2_s2  <= PW'(fy_s1) * PW'(fy_s1);
			gx2_s2  <= PW'(gx_s1) * PW'(gx_s1);
			gy2_s2  <= PW'(gy_s1) * PW'(gy_s1);
			dx2_s2  <= PW'(dx_s1) * PW'(dx_s1);
			dy2_s2  <= PW'(dy_s1) * PW'(dy_s1);
			fxdx_s2 <= PW'(fx_s1) * PW'(dx_s1);
			fydy_s2 <= PW'(fy_s1) * PW'(dy_s1);
			dxfy_s2 <= PW'(dx_s1) * PW'(fy_s1);
			dyfx_s2 <= PW'(dy_s1) * PW'(fx_s1);
			rr_s2   <= RRW'(r_s1) * RRW'(r_s1);
			mx_s2   <= MW'(r_s1) * MW'(adx);
			my_s2   <= MW'(r_s1) * MW'(ady);
			deg_s2  <= deg_s1;
		end
	end

	// stage 3: sums and sign tests
	logic signed [SW-1:0] rr_w, g0, g1, a_w, p_w, pa_w, cr_w, crm_w;
	logic                 g0_neg, g1_neg, g0_le0, g1_le0;
	sci_pkg::flag_t       flg_s3;
	logic [PW-1:0]        crm_s3, mx_s3, my_s3;

	assign rr_w   = $signed(SW'(rr_s2));
	assign g0     = SW'(fx2_s2) + SW'(fy2_s2) - rr_w;
	assign g1     = SW'(gx2_s2) + SW'(gy2_s2) - rr_w;
	assign a_w    = SW'(dx2_s2) + SW'(dy2_s2);
	assign p_w    = SW'(fxdx_s2) + SW'(fydy_s2);
	assign pa_w   = p_w + a_w;
	assign cr_w   = SW'(dxfy_s2) - SW'(dyfx_s2);
	assign crm_w  = cr_w[SW-1] ? -cr_w : cr_w;
	assign g0_neg = g0[SW-1];
	assign g1_neg = g1[SW-1];
	assign g0_le0 = g0_neg || (g0 == '0);
	assign g1_le0 = g1_neg || (g1 == '0);

	always_ff @(posedge clk) begin
		if (en3) begin
			flg_s3.deg       <= deg_s2;
			flg_s3.decided   <= g0_le0 || g1_le0;
			flg_s3.early_hit <= !(g0_neg && g1_neg);
			flg_s3.geo_ok    <= (p_w[SW-1] || (p_w == '0)) && !pa_w[SW-1];
			crm_s3           <= crm_w[PW-1:0];
			mx_s3            <= PW'(mx_s2);
			my_s3            <= PW'(my_s2);
		end
	end

	// stage 4: half-width partial products of the three squares
	logic [K2-1:0]  chh_s4, chl_s4, cll_s4;
	logic [K2-1:0]  xhh_s4, xhl_s4, xll_s4;
	logic [K2-1:0]  yhh_s4, yhl_s4, yll_s4;
	sci_pkg::flag_t flg_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			chh_s4 <= K2'(crm_s3[PW-1:K]) * K2'(crm_s3[PW-1:K]);
			chl_s4 <= K2'(crm_s3[PW-1:K]) * K2'(crm_s3[K-1:0]);
			cll_s4 <= K2'(crm_s3[K-1:0]) * K2'(crm_s3[K-1:0]);
			xhh_s4 <= K2'(mx_s3[PW-1:K]) * K2'(mx_s3[PW-1:K]);
			xhl_s4 <= K2'(mx_s3[PW-1:K]) * K2'(mx_s3[K-1:0]);
			xll_s4 <= K2'(mx_s3[K-1:0]) * K2'(mx_s3[K-1:0]);
			yhh_s4 <= K2'(my_s3[PW-1:K]) * K2'(my_s3[PW-1:K]);
			yhl_s4 <= K2'(my_s3[PW-1:K]) * K2'(my_s3[K-1:0]);
			yll_s4 <= K2'(my_s3[K-1:0]) * K2'(my_s3[K-1:0]);
			flg_s4 <= flg_s3;
		end
	end

	// stage 5: assemble squares
	logic [K4-1:0]  sqc_s5, sqx_s5, sqy_s5;
	sci_pkg::flag_t flg_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			sqc_s5 <= {chh_s4, cll_s4} + (K4'(chl_s4) << (K + 1));
			sqx_s5 <= {xhh_s4, xll_s4} + (K4'(xhl_s4) << (K + 1));
			sqy_s5 <= {yhh_s4, yll_s4} + (K4'(yhl_s4) << (K + 1));
			flg_s5 <= flg_s4;
		end
	end

	// stage 6: discriminant sign (r^2 * a >= cross^2) and final decision
	logic          disc_ok;
	logic          hit_w;
	sci_pkg::out_t out_s6;

	assign disc_ok = (QW'(sqx_s5) + QW'(sqy_s5)) >= QW'(sqc_s5);
	assign hit_w   = !flg_s5.deg
		&& (flg_s5.decided ? flg_s5.early_hit : (flg_s5.geo_ok && disc_ok));

	always_ff @(posedge clk) begin
		if (en6) begin
			out_s6.hit        <= hit_w;
			out_s6.degenerate <= flg_s5.deg;
		end
	end

	assign out_valid = v_s6;
	assign out_data  = out_s6;

endmodule

// ===== rtl/sci_checker.sv =====
// ----------------------------------------------------------------------------
// sci_checker
// Port-level checks for segment_circle_intersect, bound to the top level.
// ----------------------------------------------------------------------------
module sci_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input sci_pkg::out_t out_data
);

	localparam int OW = $clog2(sci_pkg::PIPE_DEPTH + 1);

	logic          in_txn, out_txn;
	logic [OW-1:0] occ_q;

	assign in_txn  = in_valid && in_ready;
	assign out_txn = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (in_txn && !out_txn) begin
			occ_q <= occ_q + OW'(1);
		end else if (out_txn && !in_txn) begin
			occ_q <= occ_q - OW'(1);
		end
	end

	a_deg_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.degenerate |-> !out_data.hit)
		else $error("degenerate result with hit set");

	a_out_has_src: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> occ_q != '0)
		else $error("result without an outstanding transaction");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OW'(sci_pkg::PIPE_DEPTH))
		else $error("more transactions in flight than pipeline stages");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q == '0 |-> in_ready)
		else $error("input stalled with empty pipeline");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed or dropped");

endmodule

bind segment_circle_intersect sci_checker u_sci_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

// ===== test/segment_circle_intersect_tb.sv =====
// ----------------------------------------------------------------------------
// segment_circle_intersect_tb
// Self-checking bench for the segment versus circle boundary test. A short
// table of directed queries (extremes, tangents, zero radius, zero length,
// segment inside or outside the circle) is followed by random queries, mostly
// built as local scenes around the circle so that hits, misses and boundary
// cases all occur. Results are checked against an exact wide-integer model of
// the decision or a row's fixed answer. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module segment_circle_intersect_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM   = 1530;
	localparam int STALL_MAX  = 4000;
	localparam sci_pkg::out_t ANS_DEG  = '{hit: 1'b0, degenerate: 1'b1};
	localparam sci_pkg::out_t ANS_HIT  = '{hit: 1'b1, degenerate: 1'b0};
	localparam sci_pkg::out_t ANS_MISS = '{hit: 1'b0, degenerate: 1'b0};

	typedef struct {
		sci_pkg::in_t  query;
		bit            fixed_ans;
		sci_pkg::out_t ans;
	} row_t;

	logic          clk;
	logic          arst_n;
	logic          in_valid;
	logic          in_ready;
	sci_pkg::in_t  in_data;
	logic          out_valid;
	logic          out_ready;
	sci_pkg::out_t out_data;

	sci_pkg::out_t hit_q[$];
	row_t          rows[$];
	int            mismatches = 0;
	int            n_results = 0;
	int            idle_cycles = 0;

	segment_circle_intersect u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		clk <= 1'b0;
		#5;
		clk <= 1'b1;
		#5;
	end

	function automatic sci_pkg::in_t mk(int sx, int sy, int ex, int ey, int cx, int cy,
		int r);
		sci_pkg::in_t q;
		q.start_x  = sx[15:0];
		q.start_y  = sy[15:0];
		q.end_x    = ex[15:0];
		q.end_y    = ey[15:0];
		q.center_x = cx[15:0];
		q.center_y = cy[15:0];
		q.radius   = r[14:0];
		return q;
	endfunction

	// exact decision: endpoint powers first, then vertex range and discriminant
	function automatic sci_pkg::out_t calc_crossing(sci_pkg::in_t q);
		logic signed [127:0] sx, sy, ex, ey, cx, cy, rr;
		logic signed [127:0] dx, dy, fx, fy, gx, gy, g0, g1, a, p, cr, disc;
		sci_pkg::out_t o;
		o = ANS_MISS;
		sx = $signed(q.start_x);
		sy = $signed(q.start_y);
		ex = $signed(q.end_x);
		ey = $signed(q.end_y);
		cx = $signed(q.center_x);
		cy = $signed(q.center_y);
		rr = $signed({1'b0, q.radius});
		rr = rr * rr;
		if (sx == ex && sy == ey) begin
			return ANS_DEG;
		end
		dx = ex - sx;
		dy = ey - sy;
		fx = sx - cx;
		fy = sy - cy;
		gx = ex - cx;
		gy = ey - cy;
		g0 = fx * fx + fy * fy - rr;
		g1 = gx * gx + gy * gy - rr;
		if (g0 <= 0 || g1 <= 0) begin
			o.hit = !(g0 < 0 && g1 < 0);
		end else begin
			a = dx * dx + dy * dy;
			p = fx * dx + fy * dy;
			cr = dx * fy - dy * fx;
			disc = rr * a - cr * cr;
			o.hit = (p <= 0) && (p + a >= 0) && (disc >= 0);
		end
		return o;
	endfunction

	function automatic int near(int base, int span);
		int v;
		v = base + int'($urandom_range(2 * span)) - span;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v;
	endfunction

	function automatic int any_coord();
		return int'($signed(16'($urandom)));
	endfunction

	function automatic sci_pkg::in_t random_query();
		int spans[5] = '{16, 256, 4096, 16384, 32767};
		int mode, span, sx, sy, ex, ey, cx, cy, r, dx, dy, j, off;
		sci_pkg::in_t q;
		mode = $urandom_range(9);
		span = spans[$urandom_range(4)];
		case (mode)
			0, 1: begin
				q = sci_pkg::in_t'({$urandom, $urandom, $urandom, 15'($urandom)});
			end
			6: begin
				// tangent line, or one step either side of it
				cx = near(0, 20000);
				cy = near(0, 20000);
				r = $urandom_range(4096);
				off = int'($urandom_range(2)) - 1;
				sx = near(cx, 3000);
				ex = near(cx, 3000);
				if ($urandom_range(1)) begin
					q = mk(sx, cy + r + off, ex, cy + r + off, cx, cy, r);
				end else begin
					q = mk(cx - r - off, sx, cx - r - off, ex, cx, cy, r);
				end
			end
			7: begin
				// one endpoint on the circle
				cx = near(0, 16000);
				cy = near(0, 16000);
				r = $urandom_range(16000);
				sx = $urandom_range(1) ? cx + r : cx;
				sy = (sx == cx) ? cy - r : cy;
				q = mk(sx, sy, near(sx, span), near(sy, span), cx, cy, r);
			end
			8: begin
				// point circle on or next to the segment
				sx = near(0, 16000);
				sy = near(0, 16000);
				dx = 4 * (int'($urandom_range(4000)) - 2000);
				dy = 4 * (int'($urandom_range(4000)) - 2000);
				j = $urandom_range(4);
				q = mk(sx, sy, sx + dx, sy + dy, sx + dx * j / 4, sy + dy * j / 4,
					$urandom_range(1) ? 0 : $urandom_range(2));
			end
			9: begin
				sx = any_coord();
				sy = any_coord();
				q = mk(sx, sy, sx, sy, any_coord(), any_coord(), $urandom_range(32767));
			end
			default: begin
				cx = any_coord();
				cy = any_coord();
				r = $urandom_range(span * 2 > 32767 ? 32767 : span * 2);
				q = mk(near(cx, span), near(cy, span), near(cx, span), near(cy, span),
					cx, cy, r);
			end
		endcase
		return q;
	endfunction

	task automatic send_query(sci_pkg::in_t q, bit fixed_ans, sci_pkg::out_t ans);
		in_valid <= 1'b1;
		in_data <= q;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		hit_q.insert(hit_q.size(), fixed_ans ? ans : calc_crossing(q));
	endtask

	task automatic sender_gap();
		int pick, gap;
		pick = $urandom_range(99);
		gap = (pick < 60) ? 0 : (pick < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic add_row(sci_pkg::in_t query, bit fixed_ans, sci_pkg::out_t ans);
		row_t row;
		row.query = query;
		row.fixed_ans = fixed_ans;
		row.ans = ans;
		rows.insert(rows.size(), row);
	endtask

	task automatic fill_rows();
		add_row(mk(-32768, -32768, -32768, -32768, -32768, -32768, 0), 1'b1, ANS_DEG);
		add_row(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767), 1'b1, ANS_DEG);
		add_row(mk(100, -200, 100, -200, 100, -200, 0), 1'b1, ANS_DEG);
		add_row(mk(0, 0, 16, 0, 0, 0, 0), 1'b1, ANS_HIT);
		add_row(mk(-16, 0, 16, 0, 0, 0, 0), 1'b1, ANS_HIT);
		add_row(mk(-16, 0, 16, 0, 0, 1, 0), 1'b1, ANS_MISS);
		add_row(mk(-32, 16, 32, 16, 0, 0, 16), 1'b1, ANS_HIT);
		add_row(mk(-32, 17, 32, 17, 0, 0, 16), 1'b1, ANS_MISS);
		add_row(mk(-1, 0, 1, 0, 0, 0, 16), 1'b1, ANS_MISS);
		add_row(mk(0, 0, 100, 0, 0, 0, 16), 1'b1, ANS_HIT);
		add_row(mk(100, 0, 200, 0, 0, 0, 16), 1'b1, ANS_MISS);
		add_row(mk(-16, 0, 16, 0, 0, 0, 16), 1'b1, ANS_HIT);
		add_row(mk(0, 0, 16, 0, 0, 0, 16), 1'b1, ANS_HIT);
		add_row(mk(-100, 20, 100, 20, 0, 0, 32767), 1'b1, ANS_MISS);
		add_row(mk(-32768, -32768, 32767, 32767, 0, 0, 32767), 1'b0, ANS_MISS);
		add_row(mk(32767, -32768, -32768, 32767, -32768, -32768, 32767), 1'b0, ANS_MISS);
		add_row(mk(32767, 32767, -32768, -32768, 32767, -32768, 32767), 1'b0, ANS_MISS);
		add_row(mk(32767, 32767, 32767, 32766, -32768, -32768, 32767), 1'b0, ANS_MISS);
		add_row(mk(-32768, 32767, 32767, -32768, 32767, 32767, 0), 1'b0, ANS_MISS);
		add_row(mk('h5555, 'haaaa, 'haaaa, 'h5555, 'h5555, 'haaaa, 'h2aaa), 1'b0, ANS_MISS);
		add_row(mk('haaaa, 'h5555, 'h5555, 'haaaa, 'haaaa, 'h5555, 'h5555), 1'b0, ANS_MISS);
	endtask

	// receiver: short stalls, a few long ones, and long stall-free stretches
	initial begin
		int run, stall;
		forever begin
			run = ($urandom_range(9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
			stall = ($urandom_range(9) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
			out_ready <= 1'b1;
			repeat (run) @(posedge clk);
			out_ready <= 1'b0;
			repeat (stall) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			n_results <= n_results + 1;
			if (hit_q.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10)
					$display("result %0d: unexpected transaction hit=%0b degenerate=%0b",
						n_results, out_data.hit, out_data.degenerate);
			end else begin
				if (out_data !== hit_q[0]) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("result %0d: expected hit=%0b deg=%0b, got hit=%0b deg=%0b",
							n_results, hit_q[0].hit, hit_q[0].degenerate,
							out_data.hit, out_data.degenerate);
				end
				void'(hit_q.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_MAX) begin
				$display("segment_circle_intersect_tb: FAIL");
				$finish;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		fill_rows();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) begin
			send_query(rows[i].query, rows[i].fixed_ans, rows[i].ans);
			sender_gap();
		end
		repeat (N_RANDOM) begin
			send_query(random_query(), 1'b0, ANS_MISS);
			sender_gap();
		end
		in_valid <= 1'b0;
		while (hit_q.size() != 0) @(posedge clk);
		repeat (sci_pkg::PIPE_DEPTH * 4) @(posedge clk);
		if (mismatches == 0) begin
			$display("segment_circle_intersect_tb: PASS");
		end else begin
			$display("segment_circle_intersect_tb: FAIL");
		end
		$finish;
	end

endmodule
